FILE: rtl/core/bfs_pkg.sv
// Shared constants, types and codes of the bilinear feature sampler.
`default_nettype none
package bfs_pkg;

  // Feature store geometry.
  localparam int HEIGHT   = 32;
  localparam int WIDTH    = 32;
  localparam int FRAMES   = 4;
  localparam int CHANNELS = 32;

  // At most this many results per sample beat.
  localparam int MAX_OUT  = 32;
  localparam int NCH_MAX  = (CHANNELS < MAX_OUT) ? CHANNELS : MAX_OUT;

  // Configuration port.
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CHANNELS = 2'd2;
  localparam logic [CFG_W-1:0]     CFG_RESET           = 6'd32;

  // Request kinds carried in in_tuser.
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Integer coordinates, rows, columns and channel indexes are handled at this width.
  localparam int CRD_W = 8;

  // Store address split: the row and column parities pick one of four banks.
  localparam int ROW_W      = $clog2(HEIGHT);
  localparam int COL_W      = $clog2(WIDTH);
  localparam int FRM_W      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CHN_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int BANK_AW    = (ROW_W - 1) + (COL_W - 1) + FRM_W + CHN_W;
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int NBANK      = 4;

  // Arithmetic widths.
  localparam int VAL_W  = 16;
  localparam int WGT_W  = 17;
  localparam int PROD_W = VAL_W + WGT_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int FRAC_W = 8;

  // Stream payloads.
  localparam int OCH_W       = 5;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } ctl_state_t;

  typedef struct packed {
    logic             wr;
    logic             load;
    logic             issue;
    logic [OCH_W-1:0] ch;
  } ctl_cmd_t;

  typedef struct packed {
    logic adv;
    logic nch_zero;
    logic last_ch;
    logic pipe_busy;
  } ctl_status_t;

endpackage
`default_nettype wire

FILE: rtl/core/bfs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module bfs_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [DATA_W-1:0]                    wdata,
  input  wire logic                                 re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [DATA_W-1:0]                    rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: rtl/core/bfs_ctrl.sv
// Controller of the sampler: input handshake and per-channel issue sequence.
`default_nettype none
module bfs_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  input  wire logic                 req_type,
  output logic                      in_tready,
  output bfs_pkg::ctl_cmd_t         cmd,
  input  wire bfs_pkg::ctl_status_t st
);
  import bfs_pkg::*;

  ctl_state_t       state_r, state_nxt;
  logic [OCH_W-1:0] ch_r, ch_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    cmd       = '0;
    cmd.ch    = ch_r;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (req_type == REQ_WRITE) begin
            cmd.wr = 1'b1;
          end else begin
            cmd.load = 1'b1;
            ch_nxt   = '0;
            // With no active channels a sample gives no beats at all.
            if (!st.nch_zero) begin
              state_nxt = ST_ISSUE;
            end
          end
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (st.adv) begin
          if (st.last_ch) begin
            state_nxt = ST_DRAIN;
          end else begin
            ch_nxt = ch_r + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        // The weights stay in use until the last read has been multiplied.
        if (!st.pipe_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/bfs_datapath.sv
// Datapath of the sampler: configuration, banked feature store and blend pipeline.
`default_nettype none
module bfs_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire bfs_pkg::ctl_cmd_t                 cmd,
  output bfs_pkg::ctl_status_t                   st,
  input  wire logic                              cfg_we,
  input  wire logic [bfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bfs_pkg::CFG_W-1:0]         cfg_wdata,
  input  wire logic [bfs_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [bfs_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                   out_tuser,
  output logic                                   out_tlast
);
  import bfs_pkg::*;

  localparam int OUT_PAD_W = OUT_TDATA_W - VAL_W - OCH_W;

  function automatic logic [BANK_AW-1:0] bank_addr(
    input logic [CRD_W-1:0] r,
    input logic [CRD_W-1:0] c,
    input logic [CRD_W-1:0] f,
    input logic [CRD_W-1:0] k
  );
    return {r[ROW_W-1:1], c[COL_W-1:1], f[FRM_W-1:0], k[CHN_W-1:0]};
  endfunction

  // Input fields.
  logic [4:0]       f_row, f_col, f_chn;
  logic [1:0]       f_frm;
  logic [VAL_W-1:0] f_val, f_cx, f_cy;

  assign f_row = in_tdata[4:0];
  assign f_col = in_tdata[9:5];
  assign f_frm = in_tdata[11:10];
  assign f_chn = in_tdata[16:12];
  assign f_val = in_tdata[32:17];
  assign f_cx  = in_tdata[48:33];
  assign f_cy  = in_tdata[64:49];

  // Configuration registers.
  logic [CFG_W-1:0] aw_r, ah_r, ac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_r <= CFG_RESET;
      ah_r <= CFG_RESET;
      ac_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE_WIDTH:    aw_r <= cfg_wdata;
        REG_ACTIVE_HEIGHT:   ah_r <= cfg_wdata;
        REG_ACTIVE_CHANNELS: ac_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [CRD_W-1:0] wx, wy;
  logic [CFG_W-1:0] nch;

  assign wx  = (CRD_W'(aw_r) > CRD_W'(WIDTH))  ? CRD_W'(WIDTH)  : CRD_W'(aw_r);
  assign wy  = (CRD_W'(ah_r) > CRD_W'(HEIGHT)) ? CRD_W'(HEIGHT) : CRD_W'(ah_r);
  assign nch = (ac_r > CFG_W'(NCH_MAX)) ? CFG_W'(NCH_MAX) : ac_r;

  // Sample setup, registered on the load command.
  logic [CRD_W-1:0]  lx0, ly0, lx1, ly1;
  logic [FRAC_W-1:0] dx, dy;
  logic [FRAC_W:0]   omx, omy;
  logic [2*FRAC_W+1:0] lw00, lw01, lw10, lw11;
  logic              l_ok;

  assign dx  = f_cx[FRAC_W-1:0];
  assign dy  = f_cy[FRAC_W-1:0];
  assign lx0 = CRD_W'(f_cx[VAL_W-2:FRAC_W]);
  assign ly0 = CRD_W'(f_cy[VAL_W-2:FRAC_W]);
  assign lx1 = lx0 + CRD_W'(dx != '0);
  assign ly1 = ly0 + CRD_W'(dy != '0);
  assign omx = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, dx};
  assign omy = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, dy};
  assign lw00 = omy * omx;
  assign lw01 = omy * {1'b0, dx};
  assign lw10 = {1'b0, dy} * omx;
  assign lw11 = {1'b0, dy} * {1'b0, dx};

  // Strictly inside: positive, and floor plus one still below the active size.
  assign l_ok = !f_cx[VAL_W-1] && (f_cx != '0) && !f_cy[VAL_W-1] && (f_cy != '0)
                && ((lx0 + 1'b1) < wx) && ((ly0 + 1'b1) < wy)
                && (CRD_W'(f_frm) < CRD_W'(FRAMES));

  logic             ok_r;
  logic [CRD_W-1:0] x0_r, x1_r, y0_r, y1_r, frm_r;
  logic [WGT_W-1:0] w_r [4];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ok_r   <= l_ok;
      x0_r   <= lx0;
      x1_r   <= lx1;
      y0_r   <= ly0;
      y1_r   <= ly1;
      frm_r  <= CRD_W'(f_frm);
      w_r[0] <= lw00[WGT_W-1:0];
      w_r[1] <= lw01[WGT_W-1:0];
      w_r[2] <= lw10[WGT_W-1:0];
      w_r[3] <= lw11[WGT_W-1:0];
    end
  end

  // Four parity banks; the two rows and two columns of a blend differ in parity
  // unless their fraction is zero, so each distinct neighbor comes from its own bank.
  logic                 adv;
  logic                 wr_ok;
  logic [BANK_AW-1:0]   waddr;
  logic                 bank_we [NBANK];
  logic                 bank_re;
  logic [BANK_AW-1:0]   raddr   [NBANK];
  logic [VAL_W-1:0]     rdata   [NBANK];

  assign adv     = !out_tvalid || out_tready;
  assign bank_re = adv && cmd.issue;
  assign wr_ok   = (CRD_W'(f_row) < CRD_W'(HEIGHT)) && (CRD_W'(f_col) < CRD_W'(WIDTH))
                   && (CRD_W'(f_frm) < CRD_W'(FRAMES)) && (CRD_W'(f_chn) < CRD_W'(CHANNELS));
  assign waddr   = bank_addr(CRD_W'(f_row), CRD_W'(f_col), CRD_W'(f_frm), CRD_W'(f_chn));

  always_comb begin
    logic [CRD_W-1:0] rsel, csel;
    for (int b = 0; b < NBANK; b++) begin
      rsel       = (y0_r[0] == b[1]) ? y0_r : y1_r;
      csel       = (x0_r[0] == b[0]) ? x0_r : x1_r;
      raddr[b]   = bank_addr(rsel, csel, frm_r, CRD_W'(cmd.ch));
      bank_we[b] = cmd.wr && wr_ok && ({f_row[0], f_col[0]} == 2'(b));
    end
  end

  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    bfs_ram #(
      .DATA_W (VAL_W),
      .DEPTH  (BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (bank_we[b]),
      .waddr (waddr),
      .wdata (f_val),
      .re    (bank_re),
      .raddr (raddr[b]),
      .rdata (rdata[b])
    );
  end

  // Neighbor n: bit 1 selects the lower row, bit 0 the right column.
  logic [VAL_W-1:0] nb [4];

  always_comb begin
    logic [CRD_W-1:0] ry, rx;
    for (int n = 0; n < 4; n++) begin
      ry    = n[1] ? y1_r : y0_r;
      rx    = n[0] ? x1_r : x0_r;
      nb[n] = rdata[{ry[0], rx[0]}];
    end
  end

  // Stage 1: bank data. Stage 2: products. Stage 3: sum into the output register.
  logic                    v1_r, v2_r, out_valid_r;
  logic                    rng1_r, rng2_r, out_rng_r;
  logic                    last1_r, last2_r, out_last_r;
  logic [OCH_W-1:0]        ch1_r, ch2_r, out_ch_r;
  logic signed [PROD_W-1:0] p_r   [4];
  logic signed [PROD_W-1:0] p_nxt [4];
  logic signed [SUM_W-1:0]  sum;
  logic [VAL_W-1:0]         out_val_r;

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      p_nxt[n] = '0;
      if (rng1_r) begin
        p_nxt[n] = $signed(nb[n]) * $signed({1'b0, w_r[n]});
      end
    end
  end

  assign sum = p_r[0] + p_r[1] + p_r[2] + p_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= cmd.issue;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rng1_r     <= ok_r;
      last1_r    <= st.last_ch;
      ch1_r      <= cmd.ch;
      rng2_r     <= rng1_r;
      last2_r    <= last1_r;
      ch2_r      <= ch1_r;
      for (int n = 0; n < 4; n++) begin
        p_r[n] <= p_nxt[n];
      end
      out_rng_r  <= rng2_r;
      out_last_r <= last2_r;
      out_ch_r   <= ch2_r;
      // Floor division by 2^16 is the arithmetic shift, i.e. bits 31..16.
      out_val_r  <= sum[2*VAL_W-1:VAL_W];
    end
  end

  assign st.adv       = adv;
  assign st.nch_zero  = (nch == '0);
  assign st.last_ch   = ((CFG_W'(cmd.ch) + 1'b1) == nch);
  assign st.pipe_busy = v1_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_ch_r, out_val_r};
  assign out_tuser  = out_rng_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

FILE: rtl/core/bilinear_feature_sampler_top.sv
// Top level of the bilinear feature sampler.
//
//   Channel  Direction  Beat carries
//   in_      slave      one store write or one sample request
//   out_     master     one blended value per active channel of a sample
//   cfg_     write      active width, height and channel count
//
// A write beat is taken without leaving the idle state, and so is a sample with
// no active channels. Any other sample beat is taken and then holds off the input
// while its channels are read one per cycle through the four parity banks, when
// the output is not stalled, and then while the last read reaches the multipliers.
// A read result passes the bank read, product and output registers in turn.
// Output stalls freeze the whole channel pipeline. Reset is synchronous and
// clears control state and configuration; the feature store keeps its contents.
`default_nettype none
module bilinear_feature_sampler_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Fields from bit 0: row, column, frame, channel, feature_value,
  // coord_x, coord_y, zero fill.
  input  wire logic [bfs_pkg::IN_TDATA_W-1:0]   in_tdata,
  // Field: req_type.
  input  wire logic                             in_tuser,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // Fields from bit 0: sample_value, out_channel, zero fill.
  output logic      [bfs_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // Field: in_range.
  output logic                                  out_tuser,
  output logic                                  out_tlast,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  input  wire logic                             cfg_we,
  input  wire logic [bfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bfs_pkg::CFG_W-1:0]        cfg_wdata
);
  import bfs_pkg::*;

  ctl_cmd_t    cmd;
  ctl_status_t st;

  bfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .req_type  (in_tuser),
    .in_tready (in_tready),
    .cmd       (cmd),
    .st        (st)
  );

  bfs_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

FILE: rtl/core/bfs_checker.sv
// Port-level checks of the bilinear feature sampler, bound to the top level.
`default_nettype none
module bfs_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic [bfs_pkg::IN_TDATA_W-1:0]   in_tdata,
  input wire logic                             in_tuser,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic [bfs_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input wire logic                             out_tuser,
  input wire logic                             out_tlast,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic                             cfg_we,
  input wire logic [bfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input wire logic [bfs_pkg::CFG_W-1:0]        cfg_wdata
);

  // A stalled result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // Reset leaves no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Out-of-range samples give zero values.
  a_zero_oor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[15:0] == 16'd0)
    else $error("nonzero value with in_range clear");

  // Within a sample the channel index counts up by one per beat.
  a_ch_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      !out_tvalid || out_tdata[20:16] == $past(out_tdata[20:16]) + 5'd1)
    else $error("channel index did not advance by one");

endmodule

bind bilinear_feature_sampler_top bfs_checker u_bfs_checker (.*);
`default_nettype wire
